// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lzsd_pkg.sv =====
// Shared constants, types and helpers of the LZMA stream decoder.
package lzsd_pkg;

	localparam int unsigned WINDOW_BYTES = 65536;
	localparam int unsigned PROB_ENTRIES = 32768;
	localparam int unsigned WIN_AW = $clog2(WINDOW_BYTES);
	localparam int unsigned PROB_AW = $clog2(PROB_ENTRIES);
	localparam int unsigned PROB_W = 11;

	localparam logic [31:0] TOP_VALUE = 32'h0100_0000;
	localparam logic [11:0] PROB_ONE = 12'h800;
	localparam logic [10:0] PROB_INIT = 11'd1024;

	// Probability table layout (15-bit index space)
	localparam logic [14:0] LIT_BASE = 15'h738;
	localparam logic [14:0] LIT_SPAN = 15'h300;
	localparam logic [14:0] IS_REP = 15'h0C0;
	localparam logic [14:0] IS_REP_G0 = 15'h0CC;
	localparam logic [14:0] IS_REP_G1 = 15'h0D8;
	localparam logic [14:0] IS_REP_G2 = 15'h0E4;
	localparam logic [14:0] IS_REP0_LONG = 15'h0F0;
	localparam logic [14:0] POS_SLOT = 15'h1B0;
	localparam logic [14:0] SPEC_POS = 15'h2B0;
	localparam logic [14:0] ALIGN_BASE = 15'h322;
	localparam logic [14:0] LEN_CODER = 15'h332;
	localparam logic [14:0] REP_LEN_CODER = 15'h534;

	// Opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_SUPPLY = 2'd1;
	localparam logic [1:0] OP_PULL = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_BYTE = 3'd0;
	localparam logic [2:0] ST_NEED = 3'd1;
	localparam logic [2:0] ST_ACCEPT = 3'd2;
	localparam logic [2:0] ST_FINISHED = 3'd3;
	localparam logic [2:0] ST_DATA_ERR = 3'd4;
	localparam logic [2:0] ST_BAD_PROP = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_LC = 2'd0;
	localparam logic [1:0] CFG_LP = 2'd1;
	localparam logic [1:0] CFG_PB = 2'd2;
	localparam logic [1:0] CFG_OUT_LEN = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] in_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
		logic last_byte;
	} result_t;

	typedef struct packed {
		logic [3:0] lc;
		logic [2:0] lp;
		logic [2:0] pb;
		logic [31:0] out_len;
	} cfg_t;

	typedef struct packed {
		logic we;
		logic [PROB_AW-1:0] waddr;
		logic [PROB_W-1:0] wdata;
		logic [PROB_AW-1:0] raddr;
	} prob_port_t;

	typedef struct packed {
		logic we;
		logic [WIN_AW-1:0] waddr;
		logic [7:0] wdata;
		logic [WIN_AW-1:0] raddr;
	} hist_port_t;

	typedef enum logic [4:0] {
		RP_IDLE, RP_HEADER, RP_ITEM, RP_LIT, RP_MLIT, RP_ISREP, RP_G0, RP_R0L,
		RP_G1, RP_G2, RP_LENC, RP_LENC2, RP_LENT, RP_SLOT, RP_DIRECT, RP_REV,
		RP_COPY, RP_DONE, RP_ERROR, RP_BADPROP
	} rp_t;

	typedef enum logic [3:0] {
		S_WAIT, S_CLEAR, S_RUN, S_STEP, S_PEXEC, S_HREAD, S_HDATA, S_DIST, S_EMIT
	} seq_t;

	function automatic logic [2:0] run_condition(input rp_t rp);
		logic [2:0] st;
		case (rp)
			RP_IDLE, RP_DONE: st = ST_FINISHED;
			RP_ERROR: st = ST_DATA_ERR;
			RP_BADPROP: st = ST_BAD_PROP;
			default: st = ST_ACCEPT;
		endcase
		return st;
	endfunction

endpackage

// ===== rtl/lzsd_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module lzsd_ram #(
	parameter int unsigned AW = 10,
	parameter int unsigned DW = 8
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ===== rtl/lzsd_ctrl.sv =====
// Decode sequencer: range decoder, LZ state machine and result register.
module lzsd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input lzsd_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output lzsd_pkg::result_t result,
	input lzsd_pkg::cfg_t cfg,
	output lzsd_pkg::prob_port_t prob_port,
	input logic [lzsd_pkg::PROB_W-1:0] prob_rdata,
	output lzsd_pkg::hist_port_t hist_port,
	input logic [7:0] hist_rdata
);
	import lzsd_pkg::*;

	// Control registers
	seq_t seq_q, seq_d;
	rp_t rp_q, rp_d;
	logic holdf_q, holdf_d;
	logic outv_q;
	result_t res_q, res_n;
	logic load_res;

	// Decoder state registers
	logic [31:0] range_q, range_d, code_q, code_d, pos_q, pos_d;
	logic [31:0] rep_q [4];
	logic [31:0] rep_d [4];
	logic [2:0] hdr_q, hdr_d;
	logic [3:0] lzs_q, lzs_d;
	logic [7:0] prev_q, prev_d, hold_q, hold_d, ebyte_q, ebyte_d;
	logic [8:0] pend_q, pend_d, sym_q, sym_d, mlen_q, mlen_d;
	logic [3:0] lc_q, lc_d;
	logic [2:0] lp_q, lp_d, pb_q, pb_d;
	logic [14:0] tbase_q, tbase_d, pidx_q, pidx_d, clr_q, clr_d, used_q, used_d;
	logic [4:0] left_q, left_d, loff_q, loff_d;
	logic [16:0] mbits_q, mbits_d;
	logic [5:0] wt_q, wt_d;
	logic hk_q, hk_d, dinc_q, dinc_d;

	// Shared datapath terms
	logic [3:0] pbmask, lpmask, ps;
	logic [4:0] lit_ctx, prop_sum;
	logic [14:0] lit_base, sidx;
	logic [16:0] mbits_n, used17;
	logic [31:0] split, range_bit, code_bit, hist_back, dist_val, rsh, rng_half;
	logic bitv;
	logic [10:0] pv_upd;
	logic [8:0] symn_lit, mlen_n;
	logic [6:0] symn_slot;
	logic [5:0] symn_rev, slot;
	logic [4:0] left_n, nd;
	logic props_bad;

	assign pbmask = 4'((5'd1 << pb_q) - 5'd1);
	assign lpmask = 4'((5'd1 << lp_q) - 5'd1);
	assign ps = pos_q[3:0] & pbmask;
	assign lit_ctx = 5'(9'(pos_q[3:0] & lpmask) << lc_q) + 5'(prev_q >> (4'd8 - lc_q));
	assign lit_base = LIT_BASE + (15'(lit_ctx) << 9) + (15'(lit_ctx) << 8);
	assign mbits_n = {mbits_q[15:0], 1'b0};

	// Range decoder bit on the probability read last cycle
	assign split = 32'(range_q[31:11]) * 32'(prob_rdata);
	assign bitv = (code_q >= split);
	assign range_bit = bitv ? (range_q - split) : split;
	assign code_bit = bitv ? (code_q - split) : code_q;
	assign pv_upd = bitv ? (prob_rdata - (prob_rdata >> 5))
		: (prob_rdata + 11'((PROB_ONE - 12'(prob_rdata)) >> 5));

	assign symn_lit = {sym_q[7:0], bitv};
	assign symn_slot = {sym_q[5:0], bitv};
	assign symn_rev = {sym_q[4:0], bitv};
	assign slot = symn_slot[5:0];
	assign nd = 5'(slot[5:1]) - 5'd1;
	assign rsh = 32'({1'b1, slot[0]}) << nd;
	assign left_n = left_q - 5'd1;
	assign mlen_n = 9'(loff_q) + ((loff_q == 5'd16) ? 9'(symn_lit[7:0]) : 9'(symn_lit[2:0]));
	assign hist_back = pos_q - rep_q[0];
	assign dist_val = dinc_q ? (rep_q[0] + 32'd1) : rep_q[0];
	assign rng_half = range_q >> 1;

	assign prop_sum = 5'(cfg.lc) + 5'(cfg.lp);
	assign used17 = 17'(LIT_BASE) + (17'(LIT_SPAN) << prop_sum[2:0]);
	assign props_bad = (cfg.lc > 4'd8) || (cfg.lp > 3'd4) || (cfg.pb > 3'd4)
		|| (prop_sum > 5'd5) || (used17 > 17'(PROB_ENTRIES));

	// Probability index of the current phase
	always_comb begin
		case (rp_q)
			RP_ITEM: sidx = 15'({lzs_q, ps});
			RP_MLIT: sidx = tbase_q + 15'h100 + 15'({mbits_n[8], 8'h00}) + 15'(sym_q);
			RP_ISREP: sidx = IS_REP + 15'(lzs_q);
			RP_G0: sidx = IS_REP_G0 + 15'(lzs_q);
			RP_R0L: sidx = IS_REP0_LONG + 15'({lzs_q, ps});
			RP_G1: sidx = IS_REP_G1 + 15'(lzs_q);
			RP_G2: sidx = IS_REP_G2 + 15'(lzs_q);
			RP_LENC: sidx = tbase_q;
			RP_LENC2: sidx = tbase_q + 15'd1;
			default: sidx = tbase_q + 15'(sym_q);
		endcase
	end

	// Next state
	always_comb begin
		seq_d = seq_q; rp_d = rp_q; holdf_d = holdf_q;
		load_res = 1'b0;
		res_n = '{out_byte: 8'd0, status: ST_ACCEPT, last_byte: 1'b0};
		range_d = range_q; code_d = code_q; pos_d = pos_q;
		for (int i = 0; i < 4; i++) rep_d[i] = rep_q[i];
		hdr_d = hdr_q; lzs_d = lzs_q; prev_d = prev_q; hold_d = hold_q; ebyte_d = ebyte_q;
		pend_d = pend_q; sym_d = sym_q; mlen_d = mlen_q;
		lc_d = lc_q; lp_d = lp_q; pb_d = pb_q;
		tbase_d = tbase_q; pidx_d = pidx_q; clr_d = clr_q; used_d = used_q;
		left_d = left_q; loff_d = loff_q; mbits_d = mbits_q; wt_d = wt_q;
		hk_d = hk_q; dinc_d = dinc_q;

		case (seq_q)
			S_WAIT: begin
				if (item_valid && item_ready) begin
					case (item.opcode)
						OP_START: begin
							range_d = '1; code_d = '0; hdr_d = '0; lzs_d = '0;
							for (int i = 0; i < 4; i++) rep_d[i] = 32'd1;
							pos_d = '0; prev_d = '0; pend_d = '0; sym_d = '0;
							holdf_d = 1'b0;
							if (props_bad) begin
								rp_d = RP_BADPROP;
								load_res = 1'b1;
								res_n.status = ST_BAD_PROP;
							end else begin
								lc_d = cfg.lc; lp_d = cfg.lp; pb_d = cfg.pb;
								used_d = used17[14:0];
								clr_d = '0;
								rp_d = RP_HEADER;
								seq_d = S_CLEAR;
							end
						end
						OP_PULL: seq_d = S_RUN;
						default: begin
							load_res = 1'b1;
							res_n.status = run_condition(rp_q);
							if (item.opcode == OP_SUPPLY && run_condition(rp_q) == ST_ACCEPT
									&& !holdf_q) begin
								hold_d = item.in_byte;
								holdf_d = 1'b1;
							end
						end
					endcase
				end
			end
			S_CLEAR: begin
				clr_d = clr_q + 15'd1;
				if (clr_q == used_q - 15'd1) begin
					load_res = 1'b1;
					res_n.status = ST_ACCEPT;
					seq_d = S_WAIT;
				end
			end
			S_RUN: begin
				case (rp_q)
					RP_IDLE, RP_DONE, RP_ERROR, RP_BADPROP: begin
						load_res = 1'b1;
						res_n.status = run_condition(rp_q);
						seq_d = S_WAIT;
					end
					RP_HEADER: begin
						if (!holdf_q) begin
							load_res = 1'b1;
							res_n.status = ST_NEED;
							seq_d = S_WAIT;
						end else begin
							code_d = {code_q[23:0], hold_q};
							holdf_d = 1'b0;
							hdr_d = hdr_q + 3'd1;
							if (hdr_q >= 3'd4) rp_d = RP_ITEM;
						end
					end
					RP_COPY: begin
						if (pend_q == '0) begin
							rp_d = RP_ITEM;
						end else if (pos_q >= cfg.out_len) begin
							rp_d = RP_DONE;
						end else begin
							pend_d = pend_q - 9'd1;
							hk_d = 1'b1;
							seq_d = S_HREAD;
						end
					end
					default: begin
						if (rp_q == RP_ITEM && pos_q >= cfg.out_len) begin
							rp_d = RP_DONE;
						end else if (range_q < TOP_VALUE) begin
							if (!holdf_q) begin
								load_res = 1'b1;
								res_n.status = ST_NEED;
								seq_d = S_WAIT;
							end else begin
								range_d = {range_q[23:0], 8'h00};
								code_d = {code_q[23:0], hold_q};
								holdf_d = 1'b0;
								seq_d = S_STEP;
							end
						end else begin
							seq_d = S_STEP;
						end
					end
				endcase
			end
			S_STEP: begin
				seq_d = S_RUN;
				case (rp_q)
					RP_DIRECT: begin
						range_d = rng_half;
						rep_d[0] = {rep_q[0][30:0], 1'b0};
						if (code_q >= rng_half) begin
							code_d = code_q - rng_half;
							rep_d[0] = {rep_q[0][30:0], 1'b1};
						end
						left_d = left_n;
						if (left_n == '0) begin
							rep_d[0] = {rep_d[0][27:0], 4'h0};
							tbase_d = ALIGN_BASE;
							left_d = 5'd4;
							sym_d = 9'd1;
							wt_d = 6'd1;
							rp_d = RP_REV;
						end
					end
					RP_ITEM, RP_MLIT, RP_LIT, RP_ISREP, RP_G0, RP_R0L, RP_G1, RP_G2,
					RP_LENC, RP_LENC2, RP_LENT, RP_SLOT, RP_REV: begin
						pidx_d = sidx;
						if (rp_q == RP_MLIT) mbits_d = mbits_n;
						seq_d = S_PEXEC;
					end
					default: rp_d = RP_ERROR;
				endcase
			end
			S_PEXEC: begin
				range_d = range_bit;
				code_d = code_bit;
				seq_d = S_RUN;
				case (rp_q)
					RP_ITEM: begin
						if (!bitv) begin
							sym_d = 9'd1;
							tbase_d = lit_base;
							if (lzs_q >= 4'd7) begin
								rp_d = RP_MLIT;
								hk_d = 1'b0;
								seq_d = S_HREAD;
							end else begin
								rp_d = RP_LIT;
							end
						end else begin
							rp_d = RP_ISREP;
						end
					end
					RP_MLIT, RP_LIT: begin
						sym_d = symn_lit;
						if (symn_lit[8]) begin
							ebyte_d = symn_lit[7:0];
							lzs_d = (lzs_q < 4'd4) ? 4'd0
								: ((lzs_q < 4'd10) ? lzs_q - 4'd3 : lzs_q - 4'd6);
							rp_d = RP_ITEM;
							seq_d = S_EMIT;
						end else if (rp_q == RP_MLIT && bitv != mbits_q[8]) begin
							rp_d = RP_LIT;
						end
					end
					RP_ISREP: begin
						if (!bitv) begin
							rep_d[3] = rep_q[2];
							rep_d[2] = rep_q[1];
							rep_d[1] = rep_q[0];
							lzs_d = (lzs_q < 4'd7) ? 4'd0 : 4'd3;
							tbase_d = LEN_CODER;
							rp_d = RP_LENC;
						end else begin
							rp_d = RP_G0;
						end
					end
					RP_G0: rp_d = bitv ? RP_G1 : RP_R0L;
					RP_R0L: begin
						if (!bitv) begin
							if (pos_q == '0 || rep_q[0] > pos_q) begin
								rp_d = RP_ERROR;
							end else begin
								lzs_d = (lzs_q < 4'd7) ? 4'd9 : 4'd11;
								hk_d = 1'b1;
								rp_d = RP_ITEM;
								seq_d = S_HREAD;
							end
						end else begin
							lzs_d = (lzs_q < 4'd7) ? 4'd8 : 4'd11;
							tbase_d = REP_LEN_CODER;
							rp_d = RP_LENC;
						end
					end
					RP_G1: begin
						if (!bitv) begin
							rep_d[1] = rep_q[0];
							rep_d[0] = rep_q[1];
							lzs_d = (lzs_q < 4'd7) ? 4'd8 : 4'd11;
							tbase_d = REP_LEN_CODER;
							rp_d = RP_LENC;
						end else begin
							rp_d = RP_G2;
						end
					end
					RP_G2: begin
						if (!bitv) begin
							rep_d[0] = rep_q[2];
						end else begin
							rep_d[0] = rep_q[3];
							rep_d[3] = rep_q[2];
						end
						rep_d[2] = rep_q[1];
						rep_d[1] = rep_q[0];
						lzs_d = (lzs_q < 4'd7) ? 4'd8 : 4'd11;
						tbase_d = REP_LEN_CODER;
						rp_d = RP_LENC;
					end
					RP_LENC: begin
						if (!bitv) begin
							tbase_d = tbase_q + 15'd2 + (15'(ps) << 3);
							loff_d = 5'd0;
							left_d = 5'd3;
							sym_d = 9'd1;
							rp_d = RP_LENT;
						end else begin
							rp_d = RP_LENC2;
						end
					end
					RP_LENC2: begin
						if (!bitv) begin
							tbase_d = tbase_q + 15'h82 + (15'(ps) << 3);
							loff_d = 5'd8;
							left_d = 5'd3;
						end else begin
							tbase_d = tbase_q + 15'h102;
							loff_d = 5'd16;
							left_d = 5'd8;
						end
						sym_d = 9'd1;
						rp_d = RP_LENT;
					end
					RP_LENT: begin
						sym_d = symn_lit;
						left_d = left_n;
						if (left_n == '0) begin
							mlen_d = mlen_n;
							if (lzs_q < 4'd4) begin
								lzs_d = lzs_q + 4'd7;
								tbase_d = POS_SLOT
									+ (15'((mlen_n < 9'd4) ? mlen_n[1:0] : 2'd3) << 6);
								sym_d = 9'd1;
								left_d = 5'd6;
								rp_d = RP_SLOT;
							end else begin
								dinc_d = 1'b0;
								seq_d = S_DIST;
							end
						end
					end
					RP_SLOT: begin
						sym_d = 9'(symn_slot);
						left_d = left_n;
						if (left_n == '0) begin
							if (slot < 6'd4) begin
								rep_d[0] = 32'(slot);
								dinc_d = 1'b1;
								seq_d = S_DIST;
							end else begin
								sym_d = 9'd1;
								wt_d = 6'd1;
								if (slot < 6'd14) begin
									rep_d[0] = rsh;
									tbase_d = SPEC_POS + rsh[14:0] - 15'(slot) - 15'd1;
									left_d = nd;
									rp_d = RP_REV;
								end else begin
									rep_d[0] = 32'({1'b1, slot[0]});
									left_d = nd - 5'd4;
									rp_d = RP_DIRECT;
								end
							end
						end
					end
					RP_REV: begin
						sym_d = 9'(symn_rev);
						if (bitv) rep_d[0] = rep_q[0] | 32'(wt_q);
						wt_d = {wt_q[4:0], 1'b0};
						left_d = left_n;
						if (left_n == '0) begin
							dinc_d = 1'b1;
							seq_d = S_DIST;
						end
					end
					default: rp_d = RP_ERROR;
				endcase
			end
			S_DIST: begin
				seq_d = S_RUN;
				if (dinc_q) rep_d[0] = dist_val;
				if (dinc_q && dist_val == '0) begin
					rp_d = RP_DONE;
				end else if (dist_val == '0 || dist_val > pos_q
						|| dist_val > 32'(WINDOW_BYTES)) begin
					rp_d = RP_ERROR;
				end else begin
					pend_d = mlen_q + 9'd2;
					rp_d = RP_COPY;
				end
			end
			S_HREAD: seq_d = S_HDATA;
			S_HDATA: begin
				if (hk_q) begin
					ebyte_d = hist_rdata;
					seq_d = S_EMIT;
				end else begin
					mbits_d = 17'(hist_rdata);
					seq_d = S_RUN;
				end
			end
			S_EMIT: begin
				prev_d = ebyte_q;
				pos_d = pos_q + 32'd1;
				load_res = 1'b1;
				res_n.out_byte = ebyte_q;
				res_n.status = ST_BYTE;
				res_n.last_byte = ((pos_q + 32'd1) == cfg.out_len);
				seq_d = S_WAIT;
			end
			default: seq_d = S_WAIT;
		endcase
	end

	// Outputs
	always_comb begin
		item_ready = (seq_q == S_WAIT) && (!outv_q || result_ready);
		result_valid = outv_q;
		result = res_q;
		prob_port.we = (seq_q == S_PEXEC) || (seq_q == S_CLEAR);
		prob_port.waddr = (seq_q == S_CLEAR) ? clr_q[PROB_AW-1:0] : pidx_q[PROB_AW-1:0];
		prob_port.wdata = (seq_q == S_CLEAR) ? PROB_INIT : pv_upd;
		prob_port.raddr = sidx[PROB_AW-1:0];
		hist_port.we = (seq_q == S_EMIT);
		hist_port.waddr = pos_q[WIN_AW-1:0];
		hist_port.wdata = ebyte_q;
		hist_port.raddr = hist_back[WIN_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_WAIT;
			rp_q <= RP_IDLE;
			holdf_q <= 1'b0;
			outv_q <= 1'b0;
		end else begin
			seq_q <= seq_d;
			rp_q <= rp_d;
			holdf_q <= holdf_d;
			if (load_res) outv_q <= 1'b1;
			else if (result_ready) outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) res_q <= res_n;
		range_q <= range_d; code_q <= code_d; pos_q <= pos_d;
		for (int i = 0; i < 4; i++) rep_q[i] <= rep_d[i];
		hdr_q <= hdr_d; lzs_q <= lzs_d; prev_q <= prev_d; hold_q <= hold_d;
		ebyte_q <= ebyte_d; pend_q <= pend_d; sym_q <= sym_d; mlen_q <= mlen_d;
		lc_q <= lc_d; lp_q <= lp_d; pb_q <= pb_d;
		tbase_q <= tbase_d; pidx_q <= pidx_d; clr_q <= clr_d; used_q <= used_d;
		left_q <= left_d; loff_q <= loff_d; mbits_q <= mbits_d; wt_q <= wt_d;
		hk_q <= hk_d; dinc_q <= dinc_d;
	end

endmodule

// ===== rtl/lzma_stream_decoder_top.sv =====
// Top level of the LZMA stream decoder: configuration registers and memories.
//
// Resumable LZMA decoder. Each transfer on the item channel gives exactly one
// transfer on the result channel. A start item with valid properties latches
// lc, lp and pb, clears the decoder and then sweeps the used part of the
// probability memory to 1024, one entry per cycle: 0x738 + (0x300 << (lc + lp))
// entries, at most 26424. A supply item, an unused opcode and a start with bad
// properties answer in the cycle after their transfer. A pull runs the
// sequencer until one byte comes out, more input is needed or the decoder is
// finished or in error. Every adaptive bit goes through normalize/dispatch, a
// read of the probability memory, and multiply and write-back; a direct
// distance bit skips the memory, and a header byte is shifted straight in. A
// matched literal first fetches its match byte from the history window, and a
// byte copied from a match is read from the history window and emitted. The
// probability memory has a single port pair and a registered read port.
// output_length is read live; lc, lp and pb only at start. Write configuration
// only while the decoder is idle.
module lzma_stream_decoder_top (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input lzsd_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output lzsd_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import lzsd_pkg::*;

	cfg_t cfg_q;
	prob_port_t prob_port;
	hist_port_t hist_port;
	logic [PROB_W-1:0] prob_rdata;
	logic [7:0] hist_rdata;

	// Configuration writes are always taken in one transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lc <= 4'd3;
			cfg_q.lp <= 3'd0;
			cfg_q.pb <= 3'd2;
			cfg_q.out_len <= 32'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LC: cfg_q.lc <= cfg_data[3:0];
				CFG_LP: cfg_q.lp <= cfg_data[2:0];
				CFG_PB: cfg_q.pb <= cfg_data[2:0];
				CFG_OUT_LEN: cfg_q.out_len <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Sequencer: range decoder, LZ state machine, result register
	lzsd_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result (result),
		.cfg (cfg_q),
		.prob_port (prob_port),
		.prob_rdata (prob_rdata),
		.hist_port (hist_port),
		.hist_rdata (hist_rdata)
	);

	// Adaptive bit probabilities, read-modify-write once per adaptive bit
	lzsd_ram #(.AW(PROB_AW), .DW(PROB_W)) u_prob_ram (
		.clk (clk),
		.we (prob_port.we),
		.waddr (prob_port.waddr),
		.wdata (prob_port.wdata),
		.raddr (prob_port.raddr),
		.rdata (prob_rdata)
	);

	// History window: the match source, written with every output byte
	lzsd_ram #(.AW(WIN_AW), .DW(8)) u_hist_ram (
		.clk (clk),
		.we (hist_port.we),
		.waddr (hist_port.waddr),
		.wdata (hist_port.wdata),
		.raddr (hist_port.raddr),
		.rdata (hist_rdata)
	);

endmodule

// ===== rtl/lzsd_chk.sv =====
// Port checker for the LZMA stream decoder, bound to the top level.
`include "assert_macros.svh"

module lzsd_chk (
	input logic clk,
	input logic arst_n,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input lzsd_pkg::result_t result
);
	import lzsd_pkg::*;

	`CHK_NEXT(a_res_hold, result_valid && !result_ready, result_valid, "result dropped")
	`CHK_NEXT(a_res_stable, result_valid && !result_ready, $stable(result), "result changed")
	`CHK_IMPLIES(a_last_is_byte, result_valid && result.last_byte, result.status == ST_BYTE, "last without byte")
	`CHK_IMPLIES(a_zero_byte, result_valid && result.status != ST_BYTE, result.out_byte == 8'd0, "stray byte")
	`CHK_IMPLIES(a_no_overrun, result_valid && !result_ready, !item_ready, "item taken over result")

endmodule

bind lzma_stream_decoder_top lzsd_chk u_chk (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the LZMA stream decoder: directed table, then random streams.
module tb_top;
	import lzsd_pkg::*;

	// Opcode 3 has no meaning; the decoder answers it like a dropped supply.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned ITEM_TARGET = 1000;
	localparam int unsigned N_DIR = 35;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	lzma_stream_decoder_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ------------------------------------------------------------------
	// Decoder shadow: configuration, tables and resumable decode state.
	// ------------------------------------------------------------------
	bit [31:0] cfg_lc, cfg_lp, cfg_pb, cfg_olen;
	bit [10:0] prob_mem [0:PROB_ENTRIES-1];
	bit [7:0] hist_mem [0:WINDOW_BYTES-1];
	bit [31:0] rng_v, code_v, hdr_cnt, lz_st, out_pos, prev_b, pend_len, sym;
	bit [31:0] reps [4];
	rp_t rp;
	bit [31:0] hold_b;
	bit hold_full;
	bit [31:0] lc_r, lp_r, pb_r;
	bit [31:0] tbase, nbits, mbits, loff, mlen, bweight;

	// Expected results, oldest first.
	result_t pending_results [$];
	int unsigned err_cnt;
	int unsigned items_sent;
	logic [2:0] last_status;
	bit tx_calm, rx_calm;

	function automatic bit rc_bit(input bit [31:0] idx);
		bit [14:0] k;
		bit [31:0] pv, split;
		k = idx[14:0];
		pv = {21'd0, prob_mem[k]};
		split = (rng_v >> 11) * pv;
		if (code_v < split) begin
			rng_v = split;
			prob_mem[k] = 11'(pv + ((32'h800 - pv) >> 5));
			return 1'b0;
		end
		rng_v = rng_v - split;
		code_v = code_v - split;
		prob_mem[k] = 11'(pv - (pv >> 5));
		return 1'b1;
	endfunction

	function automatic bit [31:0] back_byte(input bit [31:0] d);
		bit [31:0] a;
		a = out_pos - d;
		return {24'd0, hist_mem[a[15:0]]};
	endfunction

	function automatic bit [31:0] emit_byte(input bit [31:0] b);
		hist_mem[out_pos[15:0]] = b[7:0];
		prev_b = {24'd0, b[7:0]};
		out_pos = out_pos + 1;
		return {24'd0, b[7:0]};
	endfunction

	function automatic bit [31:0] pos_state();
		return out_pos & ((32'd1 << pb_r) - 1);
	endfunction

	function automatic bit [31:0] finish_literal();
		bit [31:0] b;
		b = emit_byte(sym);
		lz_st = lz_st < 4 ? 0 : (lz_st < 10 ? lz_st - 3 : lz_st - 6);
		rp = RP_ITEM;
		return b;
	endfunction

	function automatic void match_ready();
		if (reps[0] == 0 || reps[0] > out_pos || reps[0] > WINDOW_BYTES) begin
			rp = RP_ERROR;
			return;
		end
		pend_len = mlen + 2;
		rp = RP_COPY;
	endfunction

	function automatic void distance_done();
		reps[0] = reps[0] + 1;
		if (reps[0] == 0) rp = RP_DONE;
		else match_ready();
	endfunction

	function automatic void rep_chosen();
		lz_st = lz_st < 7 ? 8 : 11;
		tbase = REP_LEN_CODER;
		rp = RP_LENC;
	endfunction

	// One bit step of the current phase; returns 1 when a byte comes out.
	function automatic bit decode_bit_step(output bit [31:0] ob);
		bit b;
		bit [31:0] d, slot, nd, mb;
		ob = 0;
		case (rp)
			RP_ITEM: begin
				if (rc_bit((lz_st << 4) + pos_state()) == 0) begin
					sym = 1;
					tbase = LIT_BASE + LIT_SPAN * (((out_pos & ((32'd1 << lp_r) - 1)) << lc_r)
						+ (prev_b >> (8 - lc_r)));
					if (lz_st >= 7) begin
						mbits = back_byte(reps[0]);
						rp = RP_MLIT;
					end else begin
						rp = RP_LIT;
					end
				end else begin
					rp = RP_ISREP;
				end
			end
			RP_MLIT: begin
				mbits = (mbits << 1) & 32'h1FFFF;
				mb = mbits & 32'h100;
				b = rc_bit(tbase + 32'h100 + mb + sym);
				sym = (sym << 1) | b;
				if (sym >= 32'h100) begin
					ob = finish_literal();
					return 1'b1;
				end
				if (b != (mb != 0)) rp = RP_LIT;
			end
			RP_LIT: begin
				b = rc_bit(tbase + sym);
				sym = (sym << 1) | b;
				if (sym >= 32'h100) begin
					ob = finish_literal();
					return 1'b1;
				end
			end
			RP_ISREP: begin
				if (rc_bit(IS_REP + lz_st) == 0) begin
					reps[3] = reps[2];
					reps[2] = reps[1];
					reps[1] = reps[0];
					lz_st = lz_st < 7 ? 0 : 3;
					tbase = LEN_CODER;
					rp = RP_LENC;
				end else begin
					rp = RP_G0;
				end
			end
			RP_G0: rp = (rc_bit(IS_REP_G0 + lz_st) == 0) ? RP_R0L : RP_G1;
			RP_R0L: begin
				if (rc_bit(IS_REP0_LONG + (lz_st << 4) + pos_state()) == 0) begin
					if (out_pos == 0 || reps[0] > out_pos) begin
						rp = RP_ERROR;
						return 1'b0;
					end
					lz_st = lz_st < 7 ? 9 : 11;
					ob = emit_byte(back_byte(reps[0]));
					rp = RP_ITEM;
					return 1'b1;
				end
				rep_chosen();
			end
			RP_G1: begin
				if (rc_bit(IS_REP_G1 + lz_st) == 0) begin
					d = reps[1];
					reps[1] = reps[0];
					reps[0] = d;
					rep_chosen();
				end else begin
					rp = RP_G2;
				end
			end
			RP_G2: begin
				if (rc_bit(IS_REP_G2 + lz_st) == 0) begin
					d = reps[2];
				end else begin
					d = reps[3];
					reps[3] = reps[2];
				end
				reps[2] = reps[1];
				reps[1] = reps[0];
				reps[0] = d;
				rep_chosen();
			end
			RP_LENC: begin
				if (rc_bit(tbase) == 0) begin
					tbase = tbase + 2 + (pos_state() << 3);
					loff = 0;
					nbits = 3;
					sym = 1;
					rp = RP_LENT;
				end else begin
					rp = RP_LENC2;
				end
			end
			RP_LENC2: begin
				if (rc_bit(tbase + 1) == 0) begin
					tbase = tbase + 32'h82 + (pos_state() << 3);
					loff = 8;
					nbits = 3;
				end else begin
					tbase = tbase + 32'h102;
					loff = 16;
					nbits = 8;
				end
				sym = 1;
				rp = RP_LENT;
			end
			RP_LENT: begin
				b = rc_bit(tbase + sym);
				sym = ((sym << 1) | b) & 32'h1FF;
				nbits = nbits - 1;
				if (nbits != 0) return 1'b0;
				mlen = loff + (sym & (loff == 16 ? 32'hFF : 32'h7));
				if (lz_st < 4) begin
					lz_st = lz_st + 7;
					tbase = POS_SLOT + ((mlen < 4 ? mlen : 32'd3) << 6);
					sym = 1;
					nbits = 6;
					rp = RP_SLOT;
				end else begin
					match_ready();
				end
			end
			RP_SLOT: begin
				b = rc_bit(tbase + sym);
				sym = ((sym << 1) | b) & 32'h7F;
				nbits = nbits - 1;
				if (nbits != 0) return 1'b0;
				slot = sym & 63;
				if (slot < 4) begin
					reps[0] = slot;
					distance_done();
					return 1'b0;
				end
				nd = (slot >> 1) - 1;
				reps[0] = 2 | (slot & 1);
				sym = 1;
				bweight = 1;
				if (slot < 14) begin
					reps[0] = reps[0] << nd;
					tbase = SPEC_POS + reps[0] - slot - 1;
					nbits = nd;
					rp = RP_REV;
				end else begin
					nbits = nd - 4;
					rp = RP_DIRECT;
				end
			end
			RP_DIRECT: begin
				rng_v = rng_v >> 1;
				reps[0] = reps[0] << 1;
				if (code_v >= rng_v) begin
					code_v = code_v - rng_v;
					reps[0] = reps[0] | 1;
				end
				nbits = nbits - 1;
				if (nbits == 0) begin
					reps[0] = reps[0] << 4;
					tbase = ALIGN_BASE;
					nbits = 4;
					sym = 1;
					bweight = 1;
					rp = RP_REV;
				end
			end
			RP_REV: begin
				b = rc_bit(tbase + sym);
				sym = ((sym << 1) | b) & 32'h3F;
				if (b) reps[0] = reps[0] | bweight;
				bweight = bweight << 1;
				nbits = nbits - 1;
				if (nbits == 0) distance_done();
			end
			default: rp = RP_ERROR;
		endcase
		return 1'b0;
	endfunction

	function automatic logic [2:0] idle_status();
		case (rp)
			RP_IDLE, RP_DONE: return ST_FINISHED;
			RP_ERROR: return ST_DATA_ERR;
			RP_BADPROP: return ST_BAD_PROP;
			default: return ST_ACCEPT;
		endcase
	endfunction

	// Advance the decoder until one byte comes out or it stalls.
	function automatic logic [2:0] pull_byte(output bit [31:0] ob);
		ob = 0;
		while (1) begin
			if (rp == RP_IDLE || rp == RP_DONE || rp == RP_ERROR || rp == RP_BADPROP)
				return idle_status();
			if (rp == RP_HEADER) begin
				if (!hold_full) return ST_NEED;
				code_v = (code_v << 8) | hold_b;
				hold_full = 0;
				hdr_cnt = hdr_cnt + 1;
				if (hdr_cnt >= 5) rp = RP_ITEM;
				continue;
			end
			if (rp == RP_COPY) begin
				if (pend_len == 0) begin
					rp = RP_ITEM;
					continue;
				end
				if (out_pos >= cfg_olen) begin
					rp = RP_DONE;
					continue;
				end
				pend_len = pend_len - 1;
				ob = emit_byte(back_byte(reps[0]));
				return ST_BYTE;
			end
			if (rp == RP_ITEM && out_pos >= cfg_olen) begin
				rp = RP_DONE;
				continue;
			end
			if (rng_v < TOP_VALUE) begin
				if (!hold_full) return ST_NEED;
				rng_v = rng_v << 8;
				code_v = (code_v << 8) | hold_b;
				hold_full = 0;
			end
			if (decode_bit_step(ob)) return ST_BYTE;
		end
	endfunction

	function automatic logic [2:0] start_stream();
		bit [31:0] used;
		rng_v = 32'hFFFF_FFFF;
		code_v = 0;
		hdr_cnt = 0;
		lz_st = 0;
		for (int i = 0; i < 4; i++) reps[i] = 1;
		out_pos = 0;
		prev_b = 0;
		pend_len = 0;
		sym = 0;
		hold_full = 0;
		hold_b = 0;
		if (cfg_lc > 8 || cfg_lp > 4 || cfg_pb > 4 || cfg_lc + cfg_lp > 5) begin
			rp = RP_BADPROP;
			return ST_BAD_PROP;
		end
		used = LIT_BASE + (LIT_SPAN << (cfg_lc + cfg_lp));
		if (used > PROB_ENTRIES) begin
			rp = RP_BADPROP;
			return ST_BAD_PROP;
		end
		lc_r = cfg_lc;
		lp_r = cfg_lp;
		pb_r = cfg_pb;
		for (int k = 0; k < used; k++) prob_mem[k] = PROB_INIT;
		rp = RP_HEADER;
		return ST_ACCEPT;
	endfunction

	function automatic result_t decode_item(input item_t it);
		result_t r;
		bit [31:0] ob;
		logic [2:0] st;
		ob = 0;
		r = '0;
		if (it.opcode == OP_START) begin
			st = start_stream();
		end else if (it.opcode == OP_PULL) begin
			st = pull_byte(ob);
			if (st != ST_BYTE) ob = 0;
			else if (out_pos == cfg_olen) r.last_byte = 1'b1;
		end else begin
			st = idle_status();
			if (it.opcode == OP_SUPPLY && st == ST_ACCEPT && !hold_full) begin
				hold_b = {24'd0, it.in_byte};
				hold_full = 1;
			end
		end
		r.out_byte = ob[7:0];
		r.status = st;
		return r;
	endfunction

	function automatic void shadow_reset();
		cfg_lc = 3;
		cfg_lp = 0;
		cfg_pb = 2;
		cfg_olen = 0;
		for (int k = 0; k < PROB_ENTRIES; k++) prob_mem[k] = '0;
		for (int k = 0; k < WINDOW_BYTES; k++) hist_mem[k] = '0;
		rng_v = 32'hFFFF_FFFF;
		code_v = 0;
		hdr_cnt = 0;
		lz_st = 0;
		for (int i = 0; i < 4; i++) reps[i] = 1;
		out_pos = 0;
		prev_b = 0;
		pend_len = 0;
		rp = RP_IDLE;
		sym = 0;
		hold_b = 0;
		hold_full = 0;
		lc_r = 3;
		lp_r = 0;
		pb_r = 2;
		tbase = 0;
		nbits = 0;
		mbits = 0;
		loff = 0;
		mlen = 0;
		bweight = 0;
	endfunction

	// ------------------------------------------------------------------
	// Checking and helpers
	// ------------------------------------------------------------------
	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Gap length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Compare every result transfer against the oldest expectation.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result %p", result));
			end else begin
				exp_r = pending_results.pop_front();
				if (result.status !== exp_r.status)
					report($sformatf("status %0d, expected %0d", result.status, exp_r.status));
				if (result.out_byte !== exp_r.out_byte)
					report($sformatf("out_byte %02h, expected %02h", result.out_byte,
						exp_r.out_byte));
				if (result.last_byte !== exp_r.last_byte)
					report($sformatf("last_byte %0b, expected %0b", result.last_byte,
						exp_r.last_byte));
			end
		end
	end

	// Hold valid until the transfer; drop it only when a gap follows.
	// When typed is set, the typed status replaces the shadow's answer.
	task automatic send_item(input logic [1:0] op, input logic [7:0] b, input bit typed,
			input logic [2:0] typed_st);
		item_t it;
		result_t r;
		int unsigned gap;
		it.opcode = op;
		it.in_byte = b;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		r = decode_item(it);
		last_status = r.status;
		if (typed) begin
			r = '0;
			r.status = typed_st;
		end
		pending_results = {pending_results, r};
		items_sent++;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drain every outstanding result, then let the decoder settle.
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LC: cfg_lc = {28'd0, val[3:0]};
			CFG_LP: cfg_lp = {29'd0, val[2:0]};
			CFG_PB: cfg_pb = {29'd0, val[2:0]};
			default: cfg_olen = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random stream: fresh settings, a start, then mostly well-formed
	// supply/pull traffic steered by the shadow's last answer.
	task automatic random_stream();
		int unsigned r, lp, n_max, tail;
		logic [31:0] olen;
		logic [1:0] op;
		wait_idle();
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		lp = $urandom_range(0, 4);
		r = $urandom_range(0, 99);
		if (r < 60) olen = $urandom_range(1, 64);
		else if (r < 80) olen = $urandom_range(65, 400);
		else if (r < 90) olen = 0;
		else if (r < 95) olen = 32'hFFFF_FFFF;
		else olen = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			// Illegal or borderline properties now and then.
			cfg_write(CFG_LC, $urandom_range(0, 15));
			cfg_write(CFG_LP, $urandom_range(0, 7));
			cfg_write(CFG_PB, $urandom_range(0, 7));
		end else begin
			// Keep lc + lp small mostly so the table sweep stays short.
			cfg_write(CFG_LP, lp > 2 && $urandom_range(0, 3) != 0 ? 0 : lp);
			cfg_write(CFG_LC, $urandom_range(0, 5 - cfg_lp));
			cfg_write(CFG_PB, $urandom_range(0, 4));
		end
		cfg_write(CFG_OUT_LEN, olen);
		send_item(OP_START, 8'($urandom_range(0, 255)), 1'b0, ST_BYTE);
		n_max = $urandom_range(40, 300);
		tail = $urandom_range(1, 2);
		for (int unsigned i = 0; i < n_max; i++) begin
			if (last_status == ST_FINISHED || last_status == ST_DATA_ERR ||
					last_status == ST_BAD_PROP) begin
				if (tail == 0) break;
				tail--;
				op = 2'($urandom_range(1, 3));
			end else if ($urandom_range(0, 19) == 0) begin
				op = 2'($urandom_range(0, 3));
			end else if (last_status == ST_NEED) begin
				op = OP_SUPPLY;
			end else begin
				op = OP_PULL;
			end
			send_item(op, 8'($urandom_range(0, 255)), 1'b0, ST_BYTE);
		end
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	typedef struct {
		bit is_cfg;
		logic [1:0] code;
		logic [31:0] data;
		bit typed;
		logic [2:0] st;
	} dir_row_t;

	dir_row_t dir_rows [0:N_DIR-1] = '{
		// Idle after reset: everything answers finished.
		'{1'b0, OP_PULL, 32'h00, 1'b1, ST_FINISHED},
		'{1'b0, OP_SUPPLY, 32'hA5, 1'b1, ST_FINISHED},
		'{1'b0, OP_UNUSED, 32'h5A, 1'b1, ST_FINISHED},
		// lc + lp above 5
		'{1'b1, CFG_LC, 32'd6, 1'b0, ST_BYTE},
		'{1'b0, OP_START, 32'h00, 1'b1, ST_BAD_PROP},
		'{1'b0, OP_PULL, 32'h00, 1'b1, ST_BAD_PROP},
		// lc beyond 8
		'{1'b1, CFG_LC, 32'd15, 1'b0, ST_BYTE},
		'{1'b0, OP_START, 32'hFF, 1'b1, ST_BAD_PROP},
		// lp beyond 4
		'{1'b1, CFG_LC, 32'd0, 1'b0, ST_BYTE},
		'{1'b1, CFG_LP, 32'd7, 1'b0, ST_BYTE},
		'{1'b0, OP_START, 32'h00, 1'b1, ST_BAD_PROP},
		// pb beyond 4
		'{1'b1, CFG_LP, 32'd4, 1'b0, ST_BYTE},
		'{1'b1, CFG_PB, 32'd7, 1'b0, ST_BYTE},
		'{1'b0, OP_START, 32'h00, 1'b1, ST_BAD_PROP},
		// Largest legal table, zero output length.
		'{1'b1, CFG_PB, 32'd4, 1'b0, ST_BYTE},
		'{1'b1, CFG_LC, 32'd1, 1'b0, ST_BYTE},
		'{1'b1, CFG_OUT_LEN, 32'd0, 1'b0, ST_BYTE},
		'{1'b0, OP_START, 32'h00, 1'b1, ST_ACCEPT},
		'{1'b0, OP_PULL, 32'h00, 1'b1, ST_NEED},
		'{1'b0, OP_SUPPLY, 32'h00, 1'b1, ST_ACCEPT},
		// Holding register full: dropped, still accepted.
		'{1'b0, OP_SUPPLY, 32'hFF, 1'b1, ST_ACCEPT},
		'{1'b0, OP_PULL, 32'h00, 1'b0, ST_BYTE},
		'{1'b0, OP_SUPPLY, 32'hFF, 1'b0, ST_BYTE},
		'{1'b0, OP_PULL, 32'h00, 1'b0, ST_BYTE},
		'{1'b0, OP_SUPPLY, 32'h80, 1'b0, ST_BYTE},
		'{1'b0, OP_PULL, 32'h00, 1'b0, ST_BYTE},
		'{1'b0, OP_SUPPLY, 32'h7F, 1'b0, ST_BYTE},
		'{1'b0, OP_PULL, 32'h00, 1'b0, ST_BYTE},
		'{1'b0, OP_SUPPLY, 32'h01, 1'b0, ST_BYTE},
		// Header complete with zero length: finishes at once.
		'{1'b0, OP_PULL, 32'h00, 1'b0, ST_BYTE},
		// Full-range length, smallest contexts.
		'{1'b1, CFG_OUT_LEN, 32'hFFFF_FFFF, 1'b0, ST_BYTE},
		'{1'b1, CFG_LC, 32'd0, 1'b0, ST_BYTE},
		'{1'b1, CFG_LP, 32'd0, 1'b0, ST_BYTE},
		'{1'b1, CFG_PB, 32'd0, 1'b0, ST_BYTE},
		'{1'b0, OP_START, 32'h00, 1'b1, ST_ACCEPT}
	};

	// Clock: period 10.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if it never drains.
	initial begin
		int unsigned cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stalls, with calm stretches per stream.
	initial begin
		int unsigned on_len, off_len;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			on_len = $urandom_range(1, 30);
			off_len = rx_calm ? 0 : pick_gap();
			@(negedge clk);
			result_ready <= 1'b1;
			repeat (on_len - 1) @(negedge clk);
			if (off_len > 0) begin
				@(negedge clk);
				result_ready <= 1'b0;
				repeat (off_len - 1) @(negedge clk);
			end
		end
	end

	// Main sequence: reset, directed table, random streams, drain.
	initial begin
		err_cnt = 0;
		items_sent = 0;
		last_status = ST_FINISHED;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		shadow_reset();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LC;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].is_cfg) begin
				// Settings change only with nothing in flight.
				wait_idle();
				cfg_write(dir_rows[i].code, dir_rows[i].data);
			end else begin
				send_item(dir_rows[i].code, dir_rows[i].data[7:0], dir_rows[i].typed,
					dir_rows[i].st);
			end
		end

		items_sent = 0;
		while (items_sent < ITEM_TARGET) random_stream();

		wait_idle();
		repeat (50) @(posedge clk);
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lzsd_pkg.sv
rtl/lzsd_ram.sv
rtl/lzsd_ctrl.sv
rtl/lzma_stream_decoder_top.sv
rtl/lzsd_chk.sv
dv/tb_top.sv
